// ===== design/calu_pkg.sv =====
// Shared types and operation codes for the accumulator ALU.
`timescale 1ns / 1ps
`default_nettype none

package calu_pkg;

   // Operation codes carried on the request channel.
   typedef enum logic [4:0] {
      OP_OR        = 5'd0,
      OP_AND       = 5'd1,
      OP_XOR       = 5'd2,
      OP_ADC       = 5'd3,
      OP_SBC       = 5'd4,
      OP_CMP       = 5'd5,
      OP_CMP_INDEX = 5'd6,
      OP_BIT       = 5'd7,
      OP_ASL       = 5'd8,
      OP_ROL       = 5'd9,
      OP_LSR       = 5'd10,
      OP_ROR       = 5'd11,
      OP_INC       = 5'd12,
      OP_DEC       = 5'd13,
      OP_LOAD      = 5'd14,
      OP_SEC       = 5'd15,
      OP_CLC       = 5'd16,
      OP_CLV       = 5'd17,
      OP_NOP       = 5'd18
   } op_type;

   localparam int unsigned OP_WIDTH   = 5;
   localparam int unsigned BYTE_WIDTH = 8;

   // Architectural state: accumulator and the four status flags.
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] acc;
      logic                  carry;
      logic                  zero;
      logic                  negative;
      logic                  overflow;
   } alu_state_type;

endpackage

`default_nettype wire

// ===== design/calu_core.sv =====
// Combinational datapath: one ALU operation on the current accumulator and flags.
`timescale 1ns / 1ps
`default_nettype none

module calu_core (
   input  wire logic [calu_pkg::OP_WIDTH-1:0]   op,
   input  wire logic [calu_pkg::BYTE_WIDTH-1:0] operand,
   input  wire logic [calu_pkg::BYTE_WIDTH-1:0] index_value,
   input  wire logic                            on_accumulator,
   input  wire calu_pkg::alu_state_type         state_cur,
   output calu_pkg::alu_state_type              state_nxt,
   output logic [calu_pkg::BYTE_WIDTH-1:0]      value
);

   logic [7:0] a;
   logic [7:0] lhs;
   logic [7:0] rhs;
   logic       cin;
   logic [8:0] sum;
   logic [7:0] shift_src;
   logic [7:0] shift_res;
   logic       shift_carry;
   logic [7:0] mem_value;
   logic       mem_result;

   assign a = state_cur.acc;

   // Shared adder: adc adds the operand, sbc and compares add its complement.
   always_comb begin
      lhs = (op == calu_pkg::OP_CMP_INDEX) ? index_value : a;
      rhs = (op == calu_pkg::OP_ADC) ? operand : ~operand;
      cin = ((op == calu_pkg::OP_ADC) || (op == calu_pkg::OP_SBC)) ? state_cur.carry : 1'b1;
      sum = {1'b0, lhs} + {1'b0, rhs} + {8'b0, cin};
   end

   // Shifter and rotator on either the operand or the accumulator.
   always_comb begin
      shift_src = on_accumulator ? a : operand;
      if ((op == calu_pkg::OP_ASL) || (op == calu_pkg::OP_ROL)) begin
         shift_carry = shift_src[7];
         shift_res   = {shift_src[6:0], (op == calu_pkg::OP_ROL) & state_cur.carry};
      end else begin
         shift_carry = shift_src[0];
         shift_res   = {(op == calu_pkg::OP_ROR) & state_cur.carry, shift_src[7:1]};
      end
   end

   // Next state and write-back value per operation.
   always_comb begin
      state_nxt  = state_cur;
      mem_result = 1'b0;
      mem_value  = '0;
      unique case (op)
         calu_pkg::OP_OR, calu_pkg::OP_AND, calu_pkg::OP_XOR, calu_pkg::OP_LOAD: begin
            unique case (op)
               calu_pkg::OP_OR:  state_nxt.acc = a | operand;
               calu_pkg::OP_AND: state_nxt.acc = a & operand;
               calu_pkg::OP_XOR: state_nxt.acc = a ^ operand;
               default:          state_nxt.acc = operand;
            endcase
            state_nxt.negative = state_nxt.acc[7];
            state_nxt.zero     = (state_nxt.acc == 8'h00);
         end
         calu_pkg::OP_ADC: begin
            state_nxt.acc      = sum[7:0];
            state_nxt.carry    = sum[8];
            state_nxt.overflow = ~(a[7] ^ operand[7]) & (a[7] ^ sum[7]);
            state_nxt.negative = sum[7];
            state_nxt.zero     = (sum[7:0] == 8'h00);
         end
         calu_pkg::OP_SBC: begin
            state_nxt.acc      = sum[7:0];
            state_nxt.carry    = sum[8];
            state_nxt.overflow = (a[7] ^ operand[7]) & (a[7] ^ sum[7]);
            state_nxt.negative = sum[7];
            state_nxt.zero     = (sum[7:0] == 8'h00);
         end
         calu_pkg::OP_CMP, calu_pkg::OP_CMP_INDEX: begin
            state_nxt.carry    = sum[8];
            state_nxt.negative = sum[7];
            state_nxt.zero     = (lhs == operand);
         end
         calu_pkg::OP_BIT: begin
            state_nxt.negative = operand[7];
            state_nxt.overflow = operand[6];
            state_nxt.zero     = ((a & operand) == 8'h00);
         end
         calu_pkg::OP_ASL, calu_pkg::OP_ROL, calu_pkg::OP_LSR, calu_pkg::OP_ROR: begin
            state_nxt.carry    = shift_carry;
            state_nxt.negative = shift_res[7];
            state_nxt.zero     = (shift_res == 8'h00);
            if (on_accumulator) begin
               state_nxt.acc = shift_res;
            end else begin
               mem_result = 1'b1;
               mem_value  = shift_res;
            end
         end
         calu_pkg::OP_INC, calu_pkg::OP_DEC: begin
            mem_result         = 1'b1;
            mem_value          = (op == calu_pkg::OP_INC) ? operand + 8'd1 : operand - 8'd1;
            state_nxt.negative = mem_value[7];
            state_nxt.zero     = (mem_value == 8'h00);
         end
         calu_pkg::OP_SEC: state_nxt.carry    = 1'b1;
         calu_pkg::OP_CLC: state_nxt.carry    = 1'b0;
         calu_pkg::OP_CLV: state_nxt.overflow = 1'b0;
         // nop and unused codes leave the state alone
         default: state_nxt = state_cur;
      endcase
      value = mem_result ? mem_value : state_nxt.acc;
   end

endmodule

`default_nettype wire

// ===== design/cpu_alu_and_status_flags.sv =====
// Top level of the 8-bit accumulator ALU with N, Z, C and V status flags.
//
//   Channel   Direction  Payload
//   req_      in         tdata: op, operand, index_value; tuser: on_accumulator
//   rsp_      out        tdata: value, accumulator, carry, zero, negative, overflow
//
// A request is registered on entry in the input register, evaluated in one pass
// against the accumulator and flags, and the result registered in the result register.
// One request per cycle is sustained while responses are taken; the accumulator and carry
// feedback closes through the single combinational datapath in calu_core.
// Reset clears the accumulator, all flags and both valid bits.
// A stalled response holds the input register, which then stalls requests.
`timescale 1ns / 1ps
`default_nettype none

module cpu_alu_and_status_flags (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // [4:0] op, [12:5] operand, [20:13] index_value, zeros
   input  wire logic        req_tuser,  // [0] on_accumulator
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata   // [7:0] value, [15:8] accumulator, [16] carry_out,
                                        // [17] zero_out, [18] negative_out,
                                        // [19] overflow_out, zeros
);

   logic                    in_valid_ff;
   logic [4:0]              in_op_ff;
   logic [7:0]              in_operand_ff;
   logic [7:0]              in_index_ff;
   logic                    in_on_acc_ff;
   calu_pkg::alu_state_type state_ff;
   calu_pkg::alu_state_type state_in;
   logic [7:0]              value_in;
   logic                    out_valid_ff;
   logic [7:0]              out_value_ff;
   logic                    advance;

   // Move a request into the result register when it is empty or draining.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_op_ff      <= req_tdata[4:0];
         in_operand_ff <= req_tdata[12:5];
         in_index_ff   <= req_tdata[20:13];
         in_on_acc_ff  <= req_tuser;
      end
   end

   calu_core u_core (
      .op             (in_op_ff),
      .operand        (in_operand_ff),
      .index_value    (in_index_ff),
      .on_accumulator (in_on_acc_ff),
      .state_cur      (state_ff),
      .state_nxt      (state_in),
      .value          (value_in)
   );

   // Architectural state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_value_ff <= value_in;
      end
   end

   // The accumulator and flags in the response are the state the request left.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, state_ff.overflow, state_ff.negative, state_ff.zero,
                        state_ff.carry, state_ff.acc, out_value_ff};

endmodule

`default_nettype wire
